// File: sv/event_trace_ring_buffer_macros.svh
// Assertion macros shared by the trace buffer modules.
`ifndef EVENT_TRACE_RING_BUFFER_MACROS_SVH
`define EVENT_TRACE_RING_BUFFER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ETR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ETR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/etr_pkg.sv
// Shared types, codes and constants of the event trace ring buffer.
`default_nettype none

package etr_pkg;

    localparam int CAPACITY_DEF = 32;

    localparam int IN_DATA_W  = 184;
    localparam int OUT_DATA_W = 208;

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    typedef struct packed {
        logic [31:0]        seq;
        logic [63:0]        time_us;
        logic [2:0]         kind;
        logic [7:0]         channel;
        logic signed [31:0] prev_value;
        logic signed [31:0] cur_value;
    } entry_t;

    // Per-read parameters handed from the capture side to the walker
    typedef struct packed {
        logic [31:0] since;
        logic [31:0] oldest;
        logic [31:0] lost;
    } rd_req_t;

endpackage

`default_nettype wire

// File: sv/etr_mem.sv
// Entry store: one write port, one read port with registered read data.
`default_nettype none

module etr_mem #(
    parameter int CAPACITY = etr_pkg::CAPACITY_DEF,
    localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [PTR_W-1:0]     waddr,
    input  wire etr_pkg::entry_t      wdata,
    input  wire logic                 re,
    input  wire logic [PTR_W-1:0]     raddr,
    output etr_pkg::entry_t           rdata
);

    etr_pkg::entry_t store_mem [CAPACITY];
    etr_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
    end

    // Read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data_reg <= store_mem[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

`default_nettype wire

// File: sv/etr_log.sv
// Capture side: input handshake, write pointer, fill count and sequence counter.
`default_nettype none

`include "event_trace_ring_buffer_macros.svh"

module etr_log #(
    parameter int CAPACITY = etr_pkg::CAPACITY_DEF,
    localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CNT_W = $clog2(CAPACITY + 1)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           action,
    input  wire logic [63:0]          time_us,
    input  wire logic [2:0]           event_kind,
    input  wire logic [7:0]           channel_number,
    input  wire logic signed [31:0]   previous_value,
    input  wire logic signed [31:0]   current_value,
    input  wire logic [31:0]          after_seq,
    input  wire logic [5:0]           max_count,
    input  wire logic                 walk_busy,
    output logic                      mem_we,
    output logic [PTR_W-1:0]          mem_waddr,
    output etr_pkg::entry_t           mem_wdata,
    output logic                      start,
    output logic [PTR_W-1:0]          start_slot,
    output logic [CNT_W-1:0]          start_cnt,
    output logic [CNT_W-1:0]          start_lim,
    output etr_pkg::rd_req_t          start_req
);

    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]      seq_reg, seq_next;

    logic             accept;
    logic [CNT_W:0]   wp_x;
    logic [CNT_W:0]   cnt_x;
    logic [CNT_W:0]   slot_x;
    logic [31:0]      oldest;
    logic [31:0]      next_seq;

    assign in_ready = !walk_busy;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        wp_next  = wp_reg;
        cnt_next = cnt_reg;
        seq_next = seq_reg;
        mem_we   = 1'b0;
        start    = 1'b0;

        if (accept)
        begin
            case (action)
                etr_pkg::ACT_ADD:
                begin
                    mem_we   = 1'b1;
                    seq_next = seq_reg + 32'd1;
                    wp_next  = (wp_reg == PTR_W'(CAPACITY - 1)) ? '0 : wp_reg + 1'b1;
                    if (cnt_reg != CNT_W'(CAPACITY))
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                etr_pkg::ACT_CLEAR:
                begin
                    wp_next  = '0;
                    cnt_next = '0;
                    seq_next = '0;
                end
                etr_pkg::ACT_READ:
                begin
                    start = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign mem_waddr            = wp_reg;
    assign mem_wdata.seq        = seq_reg + 32'd1;
    assign mem_wdata.time_us    = time_us;
    assign mem_wdata.kind       = event_kind;
    assign mem_wdata.channel    = channel_number;
    assign mem_wdata.prev_value = previous_value;
    assign mem_wdata.cur_value  = current_value;

    // Oldest slot sits fill-count places behind the write pointer
    assign wp_x  = (CNT_W + 1)'(wp_reg);
    assign cnt_x = (CNT_W + 1)'(cnt_reg);

    always_comb
    begin
        if (wp_x >= cnt_x)
        begin
            slot_x = wp_x - cnt_x;
        end
        else
        begin
            slot_x = wp_x + (CNT_W + 1)'(CAPACITY) - cnt_x;
        end
    end

    assign start_slot = PTR_W'(slot_x);
    assign start_cnt  = cnt_reg;
    assign start_lim  = (32'(max_count) > 32'(CAPACITY)) ? CNT_W'(CAPACITY)
                                                         : CNT_W'(max_count);

    // Stored sequences are consecutive, so the oldest follows from the counters
    assign oldest   = seq_reg - 32'(cnt_reg) + 32'd1;
    assign next_seq = after_seq + 32'd1;

    assign start_req.since  = after_seq;
    assign start_req.oldest = oldest;
    assign start_req.lost   = ((start_lim == '0) || (cnt_reg == '0)) ? '0 :
                              (next_seq < oldest) ? (oldest - next_seq) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            cnt_reg <= '0;
            seq_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            cnt_reg <= cnt_next;
            seq_reg <= seq_next;
        end
    end

    `ETR_ASSERT_SAME(a_log_fill_ptr, clk, rst_n, cnt_reg < CNT_W'(CAPACITY),
        CNT_W'(wp_reg) == cnt_reg, "write pointer out of step with fill count")
    `ETR_ASSERT_SAME(a_log_no_write_in_walk, clk, rst_n, mem_we,
        !walk_busy, "store written while a read walks it")

endmodule

`default_nettype wire

// File: sv/etr_walk.sv
// Read walker: steps through retained entries, holds one lookahead entry, drives results.
`default_nettype none

`include "event_trace_ring_buffer_macros.svh"

module etr_walk #(
    parameter int CAPACITY = etr_pkg::CAPACITY_DEF,
    localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CNT_W = $clog2(CAPACITY + 1)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [PTR_W-1:0]     start_slot,
    input  wire logic [CNT_W-1:0]     start_cnt,
    input  wire logic [CNT_W-1:0]     start_lim,
    input  wire etr_pkg::rd_req_t     start_req,
    output logic                      busy,
    output logic                      mem_re,
    output logic [PTR_W-1:0]          mem_raddr,
    input  wire etr_pkg::entry_t      mem_rdata,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output etr_pkg::entry_t           out_entry,
    output logic                      out_present,
    output logic                      out_last,
    output logic [31:0]               out_lost
);

    typedef enum logic [1:0] {
        WALK_IDLE = 2'b01,
        WALK_SCAN = 2'b10
    } walk_state_t;

    walk_state_t      state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] num_reg, num_next;
    logic             pend_reg, pend_next;
    logic             out_vld_reg, out_vld_next;

    logic [PTR_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] lim_reg, lim_next;
    logic [31:0]      seq_reg, seq_next;
    logic [31:0]      since_reg, since_next;
    logic [31:0]      lost_reg, lost_next;

    etr_pkg::entry_t  out_entry_reg, out_entry_next;
    logic             out_present_reg, out_present_next;
    logic             out_last_reg, out_last_next;
    logic [31:0]      out_lost_reg, out_lost_next;

    logic             more;
    logic             hit;
    logic             out_free;
    logic             step;

    assign more     = (idx_reg < cnt_reg) && (num_reg < lim_reg);
    assign hit      = seq_reg > since_reg;
    assign out_free = !out_vld_reg || out_ready;

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        num_next         = num_reg;
        pend_next        = pend_reg;
        out_vld_next     = out_vld_reg;
        slot_next        = slot_reg;
        cnt_next         = cnt_reg;
        lim_next         = lim_reg;
        seq_next         = seq_reg;
        since_next       = since_reg;
        lost_next        = lost_reg;
        out_entry_next   = out_entry_reg;
        out_present_next = out_present_reg;
        out_last_next    = out_last_reg;
        out_lost_next    = out_lost_reg;
        mem_re           = 1'b0;
        step             = 1'b0;

        if (out_vld_reg && out_ready)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            WALK_IDLE:
            begin
                if (start)
                begin
                    slot_next  = start_slot;
                    cnt_next   = start_cnt;
                    lim_next   = start_lim;
                    seq_next   = start_req.oldest;
                    since_next = start_req.since;
                    lost_next  = start_req.lost;
                    idx_next   = '0;
                    num_next   = '0;
                    pend_next  = 1'b0;
                    state_next = WALK_SCAN;
                end
            end
            WALK_SCAN:
            begin
                if (more)
                begin
                    if (!hit)
                    begin
                        step = 1'b1;
                    end
                    else if (!pend_reg || out_free)
                    begin
                        // Fetch the next match; the held one is now known not to be last
                        step      = 1'b1;
                        mem_re    = 1'b1;
                        num_next  = num_reg + 1'b1;
                        pend_next = 1'b1;
                        if (pend_reg)
                        begin
                            out_vld_next     = 1'b1;
                            out_entry_next   = mem_rdata;
                            out_present_next = 1'b1;
                            out_last_next    = 1'b0;
                            out_lost_next    = lost_reg;
                        end
                    end
                end
                else if (out_free)
                begin
                    // Close the read: held entry as last, or an empty marker
                    out_vld_next     = 1'b1;
                    out_entry_next   = pend_reg ? mem_rdata : '0;
                    out_present_next = pend_reg;
                    out_last_next    = 1'b1;
                    out_lost_next    = lost_reg;
                    pend_next        = 1'b0;
                    state_next       = WALK_IDLE;
                end
            end
            default:
            begin
                state_next = WALK_IDLE;
            end
        endcase

        if (step)
        begin
            idx_next  = idx_reg + 1'b1;
            seq_next  = seq_reg + 32'd1;
            slot_next = (slot_reg == PTR_W'(CAPACITY - 1)) ? '0 : slot_reg + 1'b1;
        end
    end

    assign mem_raddr   = slot_reg;
    assign busy        = (state_reg == WALK_SCAN);
    assign out_valid   = out_vld_reg;
    assign out_entry   = out_entry_reg;
    assign out_present = out_present_reg;
    assign out_last    = out_last_reg;
    assign out_lost    = out_lost_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= WALK_IDLE;
            idx_reg     <= '0;
            num_reg     <= '0;
            pend_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            num_reg     <= num_next;
            pend_reg    <= pend_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg        <= slot_next;
        cnt_reg         <= cnt_next;
        lim_reg         <= lim_next;
        seq_reg         <= seq_next;
        since_reg       <= since_next;
        lost_reg        <= lost_next;
        out_entry_reg   <= out_entry_next;
        out_present_reg <= out_present_next;
        out_last_reg    <= out_last_next;
        out_lost_reg    <= out_lost_next;
    end

    `ETR_ASSERT_SAME(a_walk_idx, clk, rst_n, state_reg == WALK_SCAN,
        idx_reg <= cnt_reg, "walk index ran past the fill count")
    `ETR_ASSERT_SAME(a_walk_num, clk, rst_n, state_reg == WALK_SCAN,
        num_reg <= lim_reg, "more entries fetched than the read limit")
    `ETR_ASSERT_SAME(a_walk_marker, clk, rst_n, out_vld_reg && !out_present_reg,
        out_last_reg, "empty marker not flagged as last")
    `ETR_ASSERT_NEXT(a_walk_fetch, clk, rst_n, mem_re,
        pend_reg && (state_reg == WALK_SCAN), "fetched entry not held")

endmodule

`default_nettype wire

// File: sv/event_trace_ring_buffer.sv
// Top level of the event trace ring buffer.
//
//  Channel    Dir  tdata                                        tuser           tlast
//  s_axis     in   time, kind, channel, prev, cur, since, max   action          -
//  m_axis     out  seq, time, kind, channel, prev, cur, lost    entry_present   last_of_read
//
//  Add and clear take effect when accepted; an add can be accepted in every cycle unless a read walks the store.
//  A read occupies the walker while it steps through the stored entries, one per
//  cycle through the single read port of the entry store while the output is not stalled.
//  No input transaction is taken while a read walks the store.
//  Reset clears pointer, fill count and sequence; the store contents are left as is.
//  A stalled output transaction holds its register; the walker waits behind it before it emits another.
`default_nettype none

module event_trace_ring_buffer #(
    parameter int CAPACITY = etr_pkg::CAPACITY_DEF,
    localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CNT_W = $clog2(CAPACITY + 1)
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // time_us[63:0], event_kind[66:64], channel_number[74:67], previous_value[106:75],
    // current_value[138:107], after_seq[170:139], max_count[176:171], zero[183:177]
    input  wire logic [etr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // action[1:0]
    input  wire logic [1:0]                      s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // entry_seq[31:0], entry_time_us[95:32], entry_kind[98:96], entry_channel[106:99],
    // entry_previous[138:107], entry_current[170:139], lost_count[202:171], zero[207:203]
    output logic [etr_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // entry_present
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tlast
);

    logic                 walk_busy;
    logic                 mem_we;
    logic [PTR_W-1:0]     mem_waddr;
    etr_pkg::entry_t      mem_wdata;
    logic                 mem_re;
    logic [PTR_W-1:0]     mem_raddr;
    etr_pkg::entry_t      mem_rdata;
    logic                 start;
    logic [PTR_W-1:0]     start_slot;
    logic [CNT_W-1:0]     start_cnt;
    logic [CNT_W-1:0]     start_lim;
    etr_pkg::rd_req_t     start_req;
    etr_pkg::entry_t      out_entry;
    logic [31:0]          out_lost;

    etr_log #(
        .CAPACITY (CAPACITY)
    ) u_log (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .action         (s_axis_tuser),
        .time_us        (s_axis_tdata[63:0]),
        .event_kind     (s_axis_tdata[66:64]),
        .channel_number (s_axis_tdata[74:67]),
        .previous_value (s_axis_tdata[106:75]),
        .current_value  (s_axis_tdata[138:107]),
        .after_seq      (s_axis_tdata[170:139]),
        .max_count      (s_axis_tdata[176:171]),
        .walk_busy      (walk_busy),
        .mem_we         (mem_we),
        .mem_waddr      (mem_waddr),
        .mem_wdata      (mem_wdata),
        .start          (start),
        .start_slot     (start_slot),
        .start_cnt      (start_cnt),
        .start_lim      (start_lim),
        .start_req      (start_req)
    );

    etr_mem #(
        .CAPACITY (CAPACITY)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    etr_walk #(
        .CAPACITY (CAPACITY)
    ) u_walk (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .start_slot  (start_slot),
        .start_cnt   (start_cnt),
        .start_lim   (start_lim),
        .start_req   (start_req),
        .busy        (walk_busy),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_entry   (out_entry),
        .out_present (m_axis_tuser),
        .out_last    (m_axis_tlast),
        .out_lost    (out_lost)
    );

    assign m_axis_tdata = {5'b0, out_lost, out_entry.cur_value, out_entry.prev_value,
                           out_entry.channel, out_entry.kind, out_entry.time_us,
                           out_entry.seq};

endmodule

`default_nettype wire
